>>> hw/rtl/gyro_bias_calibrator_assert.svh
// Assertion macros for the gyro bias calibrator checker.
`ifndef GYRO_BIAS_CALIBRATOR_ASSERT_SVH
`define GYRO_BIAS_CALIBRATOR_ASSERT_SVH

// Checked only while out of reset.
`define GBC_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("gbc assertion failed");

// Checked at every edge, reset included.
`define GBC_ASSERT_ALWAYS(lbl, prop) \
  lbl: assert property (@(posedge clk) prop) \
    else $error("gbc assertion failed");

`endif

>>> hw/rtl/gbc_pkg.sv
// Types and constants shared by the gyro bias calibrator modules.
package gbc_pkg;

  localparam int NUM_AXES = 3;
  localparam int RATE_W   = 16;
  localparam int SUM_W    = 26;
  localparam int BIAS_W   = 24;
  localparam int SPREAD_W = 17;
  localparam int NUM_W    = 34;
  localparam int STEP_W   = 6;
  localparam int WCNT_W   = 10;
  localparam int ADDR_W   = 3;
  localparam int DATA_W   = 32;

  localparam logic [STEP_W-1:0] DIV_LAST_STEP = 6'd33;

  localparam logic [NUM_W-1:0] BIAS_POS_LIM = 34'd8388607;
  localparam logic [NUM_W-1:0] BIAS_NEG_LIM = 34'd8388608;
  localparam logic signed [BIAS_W-1:0] BIAS_MAX = 24'sh7FFFFF;
  localparam logic signed [BIAS_W-1:0] BIAS_MIN = 24'sh800000;

  localparam logic signed [RATE_W-1:0] RATE_MAX = 16'sh7FFF;
  localparam logic signed [RATE_W-1:0] RATE_MIN = 16'sh8000;

  localparam logic [15:0] THR_RESET = 16'd286;
  localparam logic        REG_STILL_THRESHOLD = 1'b0;

  typedef struct packed {
    logic signed [RATE_W-1:0] rate_x;
    logic signed [RATE_W-1:0] rate_y;
    logic signed [RATE_W-1:0] rate_z;
    logic                     last_sample;
  } in_word_t;

  typedef struct packed {
    logic                     is_still;
    logic signed [BIAS_W-1:0] bias_x;
    logic signed [BIAS_W-1:0] bias_y;
    logic signed [BIAS_W-1:0] bias_z;
    logic [WCNT_W-1:0]        window_count;
  } out_word_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_EVAL,
    ST_DIV,
    ST_DONE
  } gbc_state_t;

  typedef struct packed {
    logic acc;
    logic clr;
    logic div_load;
    logic div_step;
  } lane_ctl_t;

  typedef struct packed {
    logic load;
    logic still;
  } merge_ctl_t;

endpackage

>>> hw/rtl/gbc_lane.sv
// One axis lane: running sum, min and max, and a restoring mean divider.
module gbc_lane
  import gbc_pkg::*;
#(
  parameter int CNT_W = 10
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  lane_ctl_t                ctl,
  input  logic signed [RATE_W-1:0] sample,
  input  logic [CNT_W-1:0]         divisor,
  output logic [SPREAD_W-1:0]      spread,
  output logic signed [BIAS_W-1:0] mean
);

  logic signed [SUM_W-1:0]  sum_r, sum_nxt;
  logic signed [RATE_W-1:0] min_r, min_nxt;
  logic signed [RATE_W-1:0] max_r, max_nxt;
  logic [NUM_W-1:0]         num_r, num_nxt;
  logic [CNT_W-1:0]         rem_r, rem_nxt;
  logic                     neg_r, neg_nxt;

  logic [CNT_W:0]   trial;
  logic [CNT_W:0]   diff;
  logic             ge;
  logic [SUM_W-1:0] mag;

  always_comb begin
    sum_nxt = sum_r;
    min_nxt = min_r;
    max_nxt = max_r;
    if (ctl.clr) begin
      sum_nxt = '0;
      min_nxt = RATE_MAX;
      max_nxt = RATE_MIN;
    end else if (ctl.acc) begin
      sum_nxt = sum_r + SUM_W'(sample);
      if (sample < min_r) min_nxt = sample;
      if (sample > max_r) max_nxt = sample;
    end
  end

  always_comb begin
    trial = {rem_r, num_r[NUM_W-1]};
    diff  = trial - {1'b0, divisor};
    ge    = (trial >= {1'b0, divisor});
    mag   = sum_r[SUM_W-1] ? (~sum_r + 1'b1) : sum_r;
    num_nxt = num_r;
    rem_nxt = rem_r;
    neg_nxt = neg_r;
    if (ctl.div_load) begin
      neg_nxt = sum_r[SUM_W-1];
      num_nxt = {mag, 8'd0};
      rem_nxt = '0;
    end else if (ctl.div_step) begin
      rem_nxt = ge ? diff[CNT_W-1:0] : trial[CNT_W-1:0];
      num_nxt = {num_r[NUM_W-2:0], ge};
    end
  end

  always_comb begin
    if (!neg_r) begin
      mean = (num_r > BIAS_POS_LIM) ? BIAS_MAX : num_r[BIAS_W-1:0];
    end else begin
      mean = (num_r > BIAS_NEG_LIM) ? BIAS_MIN : (~num_r[BIAS_W-1:0] + 1'b1);
    end
  end

  assign spread = {max_r[RATE_W-1], max_r} - {min_r[RATE_W-1], min_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sum_r <= '0;
      min_r <= RATE_MAX;
      max_r <= RATE_MIN;
    end else begin
      sum_r <= sum_nxt;
      min_r <= min_nxt;
      max_r <= max_nxt;
    end
  end

  always_ff @(posedge clk) begin
    num_r <= num_nxt;
    rem_r <= rem_nxt;
    neg_r <= neg_nxt;
  end

endmodule

>>> hw/rtl/gbc_merge.sv
// Merge stage: stored bias update and the result word register.
module gbc_merge
  import gbc_pkg::*;
(
  input  logic                     clk,
  input  logic                     rst_n,
  input  merge_ctl_t               ctl,
  input  logic signed [BIAS_W-1:0] mean [NUM_AXES],
  input  logic [WCNT_W-1:0]        count,
  input  logic                     out_ready,
  output logic                     out_valid,
  output out_word_t                out_data
);

  logic signed [BIAS_W-1:0] bias_r   [NUM_AXES];
  logic signed [BIAS_W-1:0] bias_nxt [NUM_AXES];
  logic                     out_valid_r, out_valid_nxt;
  out_word_t                out_data_r, out_data_nxt;

  always_comb begin
    for (int a = 0; a < NUM_AXES; a++) begin
      bias_nxt[a] = (ctl.load && ctl.still) ? mean[a] : bias_r[a];
    end
    out_valid_nxt = out_valid_r;
    out_data_nxt  = out_data_r;
    if (ctl.load) begin
      out_valid_nxt             = 1'b1;
      out_data_nxt.is_still     = ctl.still;
      out_data_nxt.bias_x       = bias_nxt[0];
      out_data_nxt.bias_y       = bias_nxt[1];
      out_data_nxt.bias_z       = bias_nxt[2];
      out_data_nxt.window_count = count;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
      for (int a = 0; a < NUM_AXES; a++) bias_r[a] <= '0;
    end else begin
      out_valid_r <= out_valid_nxt;
      for (int a = 0; a < NUM_AXES; a++) bias_r[a] <= bias_nxt[a];
    end
  end

  always_ff @(posedge clk) begin
    out_data_r <= out_data_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

>>> hw/rtl/gyro_bias_calibrator.sv
// Top level of the gyro zero-rate bias calibrator.
// Usage:
//   in_* takes one three-axis raw sample word per valid/ready handshake;
//   last_sample marks the end of a calibration window, which also closes
//   by itself when the count reaches MAX_SAMPLES.
//   out_* gives one word per closed window: is_still, the stored biases
//   (8 fraction bits) and the window sample count.
//   The APB port holds still_threshold at address 0; pready is tied high.
// Timing:
//   A sample that does not close the window goes into the lane sums at its
//   handshake. A closing sample: spread check in ST_EVAL, then the per-lane
//   one-bit-per-cycle restoring divider in ST_DIV (skipped when not still),
//   then ST_DONE loads the result register once no word is pending or it is taken.
//   in_ready stays low from the closing sample until the result register
//   is loaded.
// Stall: the result waits in its register; new samples are still taken,
//   and the next window's result waits until the pending word is taken.
// Reset: threshold 286, stored bias 0, accumulators cleared, no result.
module gyro_bias_calibrator
  import gbc_pkg::*;
#(
  parameter int MAX_SAMPLES = 512
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  in_word_t          in_data,
  output logic              out_valid,
  input  logic              out_ready,
  output out_word_t         out_data,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [ADDR_W-1:0] paddr,
  input  logic [DATA_W-1:0] pwdata,
  output logic [DATA_W-1:0] prdata,
  output logic              pready
);

  localparam int CNT_W = $clog2(MAX_SAMPLES + 1);
  localparam logic [CNT_W-1:0] MAX_CNT = CNT_W'(MAX_SAMPLES);

  gbc_state_t state_r, state_nxt;
  logic [15:0]       thr_r, thr_nxt;
  logic [CNT_W-1:0]  total_r, total_nxt;
  logic [CNT_W-1:0]  total_inc;
  logic [STEP_W-1:0] step_r, step_nxt;
  logic              still_r, still_nxt;
  logic              closing;
  logic              still;
  logic              out_free;
  logic              cfg_wr;
  logic [CNT_W+WCNT_W-1:0] count_ext;

  lane_ctl_t  lane_ctl;
  merge_ctl_t merge_ctl;

  logic signed [RATE_W-1:0] lane_smp    [NUM_AXES];
  logic [SPREAD_W-1:0]      lane_spread [NUM_AXES];
  logic signed [BIAS_W-1:0] lane_mean   [NUM_AXES];

  assign lane_smp[0] = in_data.rate_x;
  assign lane_smp[1] = in_data.rate_y;
  assign lane_smp[2] = in_data.rate_z;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && (paddr[2] == REG_STILL_THRESHOLD);
  assign prdata = (paddr[2] == REG_STILL_THRESHOLD) ? {16'd0, thr_r} : '0;
  assign thr_nxt = cfg_wr ? pwdata[15:0] : thr_r;

  assign total_inc = total_r + 1'b1;
  assign closing   = in_data.last_sample || (total_inc == MAX_CNT);
  assign out_free  = !out_valid || out_ready;
  assign count_ext = {{WCNT_W{1'b0}}, total_r};

  always_comb begin
    still = 1'b1;
    for (int a = 0; a < NUM_AXES; a++) begin
      if (lane_spread[a] > {1'b0, thr_r}) still = 1'b0;
    end
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: if (in_valid && closing) state_nxt = ST_EVAL;
      ST_EVAL: state_nxt = still ? ST_DIV : ST_DONE;
      ST_DIV:  if (step_r == DIV_LAST_STEP) state_nxt = ST_DONE;
      ST_DONE: if (out_free) state_nxt = ST_IDLE;
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    in_ready           = 1'b0;
    lane_ctl           = '0;
    merge_ctl          = '0;
    merge_ctl.still    = still_r;
    total_nxt          = total_r;
    step_nxt           = step_r;
    still_nxt          = still_r;
    case (state_r)
      ST_IDLE: begin
        in_ready     = 1'b1;
        lane_ctl.acc = in_valid;
        if (in_valid) total_nxt = total_inc;
      end
      ST_EVAL: begin
        still_nxt         = still;
        lane_ctl.div_load = still;
        step_nxt          = '0;
      end
      ST_DIV: begin
        lane_ctl.div_step = 1'b1;
        step_nxt          = step_r + 1'b1;
      end
      ST_DONE: begin
        lane_ctl.clr   = out_free;
        merge_ctl.load = out_free;
        if (out_free) total_nxt = '0;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      thr_r   <= THR_RESET;
      total_r <= '0;
      step_r  <= '0;
      still_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      thr_r   <= thr_nxt;
      total_r <= total_nxt;
      step_r  <= step_nxt;
      still_r <= still_nxt;
    end
  end

  for (genvar g = 0; g < NUM_AXES; g++) begin : g_lane
    gbc_lane #(
      .CNT_W(CNT_W)
    ) u_lane (
      .clk    (clk),
      .rst_n  (rst_n),
      .ctl    (lane_ctl),
      .sample (lane_smp[g]),
      .divisor(total_r),
      .spread (lane_spread[g]),
      .mean   (lane_mean[g])
    );
  end

  gbc_merge u_merge (
    .clk      (clk),
    .rst_n    (rst_n),
    .ctl      (merge_ctl),
    .mean     (lane_mean),
    .count    (count_ext[WCNT_W-1:0]),
    .out_ready(out_ready),
    .out_valid(out_valid),
    .out_data (out_data)
  );

endmodule

>>> hw/rtl/gbc_checker.sv
// Port-level assertion checker for the gyro bias calibrator, with its bind.
`include "gyro_bias_calibrator_assert.svh"

module gbc_checker
  import gbc_pkg::*;
(
  input logic      clk,
  input logic      rst_n,
  input logic      in_valid,
  input logic      in_ready,
  input in_word_t  in_data,
  input logic      out_valid,
  input logic      out_ready,
  input out_word_t out_data,
  input logic      pready
);

  `GBC_ASSERT(a_out_hold, out_valid && !out_ready |=> out_valid && $stable(out_data))
  `GBC_ASSERT(a_close_blocks, in_valid && in_ready && in_data.last_sample |=> !in_ready)
  `GBC_ASSERT_ALWAYS(a_rst_no_out, !rst_n |=> !out_valid)
  `GBC_ASSERT_ALWAYS(a_pready_high, pready)

endmodule

bind gyro_bias_calibrator gbc_checker u_gbc_checker (
  .clk      (clk),
  .rst_n    (rst_n),
  .in_valid (in_valid),
  .in_ready (in_ready),
  .in_data  (in_data),
  .out_valid(out_valid),
  .out_ready(out_ready),
  .out_data (out_data),
  .pready   (pready)
);
